FILE: rtl/gppt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gppt_pkg: shared types and constants for the GF(2) primitive polynomial test
// Holds the widths, the sequencer state type, the handshakes between the
// sequencer and its two step units, and the degree-divisibility table.
// ----------------------------------------------------------------------------
package gppt_pkg;

    // largest supported degree and derived widths
    localparam int MAX_DEGREE = 16;
    localparam int DW         = 16;   // coefficient / period word width
    localparam int PW         = DW + 1; // full polynomial incl. leading term
    localparam int DEG_W      = 5;    // width of the degree register
    localparam int IW         = 4;    // divisor degree counter, 1..9
    localparam int HALF_MAX   = MAX_DEGREE / 2;

    localparam logic [DEG_W-1:0] DEG_RESET = 5'd8;
    localparam logic [DEG_W-1:0] DEG_MIN   = 5'd2;
    localparam logic [DEG_W-1:0] DEG_MAX   = 5'(MAX_DEGREE);

    // bit i of entry n is set when i divides n, i.e. 2^i-1 divides 2^n-1
    localparam logic [HALF_MAX:0] DEG_DIV_MASK [0:MAX_DEGREE] = '{
        9'b000000000,  // 0
        9'b000000010,  // 1
        9'b000000110,  // 2
        9'b000001010,  // 3
        9'b000010110,  // 4
        9'b000100010,  // 5
        9'b001001110,  // 6
        9'b010000010,  // 7
        9'b100010110,  // 8
        9'b000001010,  // 9
        9'b000100110,  // 10
        9'b000000010,  // 11
        9'b001011110,  // 12
        9'b000000010,  // 13
        9'b010000110,  // 14
        9'b000101010,  // 15
        9'b100010110   // 16
    };

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_DLOAD,
        S_DIV,
        S_LFSR,
        S_OUT
    } t_state;

    // trial division unit control / status
    typedef struct packed {
        logic             start;
        logic [DEG_W-1:0] steps;
    } t_div_cmd;

    typedef struct packed {
        logic done;
        logic exact;
    } t_div_sts;

    // LFSR period unit status
    typedef struct packed {
        logic done;
        logic [DW-1:0] period;
    } t_lfsr_sts;

endpackage

FILE: rtl/gf2_primitive_polynomial_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_primitive_polynomial_test: primitive test for monic GF(2) polynomials
// Trial division by small monic divisors whose degree divides n, then an LFSR period count.
// ----------------------------------------------------------------------------
// Usage: write the degree n on i_cfg_we/i_cfg_wdata while busy is low (values
// below 2 act as 2, above 16 as 16). A word is taken when start is high and
// busy is low; busy then stays high until the result has been shown. The
// result is on the o_ ports for exactly one cycle with o_valid high and
// cannot be held off. Per word, for every divisor degree i <= n/2 that
// divides n, the block makes up to 2^i-1 trial divisions, stopping at
// the first exact one (one shared shift/xor unit clearing one bit a
// cycle). A word with no divisor found then runs the LFSR one step a
// cycle for up to 2^n-1 steps before the result is shown.
// ----------------------------------------------------------------------------
module gf2_primitive_polynomial_test (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gppt_pkg::DEG_W-1:0]       i_cfg_wdata,
    input  logic                             start,
    input  logic [gppt_pkg::DW-1:0]          i_low_coeffs,
    output logic                             busy,
    output logic                             o_valid,
    output logic                             o_is_primitive,
    output logic                             o_found_divisor,
    output logic [gppt_pkg::DW-1:0]          o_lfsr_period
);
    import gppt_pkg::*;

    t_state r_state, n_state;

    logic [DEG_W-1:0] r_deg;
    logic [DEG_W-1:0] r_n,     n_n;
    logic [PW-1:0]    r_p_top, n_p_top;
    logic [DW-1:0]    r_taps,  n_taps;
    logic [DW-1:0]    r_mask,  n_mask;
    logic [IW-1:0]    r_i,     n_i;
    logic [DW-1:0]    r_dinc,  n_dinc;
    logic [DW-1:0]    r_dlow,  n_dlow;
    logic             r_prim,  n_prim;
    logic             r_found, n_found;
    logic [DW-1:0]    r_per,   n_per;

    logic [DEG_W-1:0] eff_n;
    logic [PW-1:0]    mask_full;
    logic [DW-1:0]    low_m;
    logic [DW-1:0]    low_rev;
    logic [PW-1:0]    poly_full;
    logic [DW:0]      dsum;

    t_div_cmd  div_cmd;
    t_div_sts  div_sts;
    logic      lfsr_start;
    t_lfsr_sts lfsr_sts;

    // degree register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= DEG_RESET;
        end else if (i_cfg_we) begin
            r_deg <= i_cfg_wdata;
        end
    end

    // input word conditioning: clamp degree, mask, align, reverse for taps
    always_comb begin
        if (r_deg < DEG_MIN) begin
            eff_n = DEG_MIN;
        end else if (r_deg > DEG_MAX) begin
            eff_n = DEG_MAX;
        end else begin
            eff_n = r_deg;
        end
        mask_full = (17'd1 << eff_n) - 17'd1;
        low_m     = i_low_coeffs & mask_full[DW-1:0];
        for (int j = 0; j < DW; j++) begin
            low_rev[DW-1-j] = low_m[j];
        end
        poly_full = {1'b0, low_m} | (17'd1 << eff_n);
    end

    // state register and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_p_top <= n_p_top;
        r_taps  <= n_taps;
        r_mask  <= n_mask;
        r_i     <= n_i;
        r_dinc  <= n_dinc;
        r_dlow  <= n_dlow;
        r_prim  <= n_prim;
        r_found <= n_found;
        r_per   <= n_per;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_p_top     = r_p_top;
        n_taps      = r_taps;
        n_mask      = r_mask;
        n_i         = r_i;
        n_dinc      = r_dinc;
        n_dlow      = r_dlow;
        n_prim      = r_prim;
        n_found     = r_found;
        n_per       = r_per;
        div_cmd     = '0;
        lfsr_start  = 1'b0;
        dsum        = {1'b0, r_dlow} + {1'b0, r_dinc};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_n     = eff_n;
                    n_p_top = poly_full << (DEG_MAX - eff_n);
                    n_taps  = low_rev >> (DEG_MAX - eff_n);
                    n_mask  = mask_full[DW-1:0];
                    n_i     = 4'd1;
                    n_dinc  = 16'h8000;
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if ({1'b0, r_i} > (r_n >> 1)) begin
                    // no divisor found: measure the period
                    lfsr_start = 1'b1;
                    n_state    = S_LFSR;
                end else if (DEG_DIV_MASK[r_n][r_i]) begin
                    n_dlow  = r_dinc;
                    n_state = S_DLOAD;
                end else begin
                    n_i    = r_i + 4'd1;
                    n_dinc = r_dinc >> 1;
                end
            end
            S_DLOAD: begin
                div_cmd.start = 1'b1;
                div_cmd.steps = r_n - {1'b0, r_i} + 5'd1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                if (div_sts.done) begin
                    if (div_sts.exact) begin
                        n_found = 1'b1;
                        n_prim  = 1'b0;
                        n_per   = '0;
                        n_state = S_OUT;
                    end else if (dsum[DW]) begin
                        // all divisors of this degree done
                        n_i     = r_i + 4'd1;
                        n_dinc  = r_dinc >> 1;
                        n_state = S_SEL;
                    end else begin
                        n_dlow  = dsum[DW-1:0];
                        n_state = S_DLOAD;
                    end
                end
            end
            S_LFSR: begin
                if (lfsr_sts.done) begin
                    n_found = 1'b0;
                    n_per   = lfsr_sts.period;
                    n_prim  = (lfsr_sts.period == r_mask);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    gppt_div_unit u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .i_dividend (r_p_top),
        .i_divisor  ({1'b1, r_dlow}),
        .o_sts      (div_sts)
    );

    gppt_lfsr_unit u_lfsr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lfsr_start),
        .i_taps  (r_taps),
        .i_mask  (r_mask),
        .o_sts   (lfsr_sts)
    );

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_is_primitive  = r_prim;
    assign o_found_divisor = r_found;
    assign o_lfsr_period   = r_per;

endmodule

FILE: rtl/gppt_div_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gppt_div_unit: GF(2) long division, one quotient bit per cycle
// Operands are left aligned at bit 16. Each cycle the top bit is cleared by
// an xor with the divisor when set, then the remainder shifts up one place.
// ----------------------------------------------------------------------------
module gppt_div_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  gppt_pkg::t_div_cmd     i_cmd,
    input  logic [gppt_pkg::PW-1:0] i_dividend,
    input  logic [gppt_pkg::PW-1:0] i_divisor,
    output gppt_pkg::t_div_sts     o_sts
);
    import gppt_pkg::*;

    logic [PW-1:0]    r_rem;
    logic [PW-1:0]    r_div;
    logic [DEG_W-1:0] r_cnt;
    logic             r_run;

    // control: run flag and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.start) begin
            r_run <= 1'b1;
            r_cnt <= i_cmd.steps;
        end else if (r_run) begin
            if (r_cnt == '0) begin
                r_run <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    // datapath: shared shift/xor step
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_dividend;
            r_div <= i_divisor;
        end else if (r_run && (r_cnt != '0)) begin
            r_rem <= (r_rem ^ (r_rem[PW-1] ? r_div : '0)) << 1;
        end
    end

    assign o_sts.done  = r_run && (r_cnt == '0);
    assign o_sts.exact = (r_rem == '0);

endmodule

FILE: rtl/gppt_lfsr_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gppt_lfsr_unit: Fibonacci LFSR period counter
// Starts from state 1 and steps once per cycle until the state returns to 1
// or the step count reaches the order mask with no return, which reports period 0.
// ----------------------------------------------------------------------------
module gppt_lfsr_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [gppt_pkg::DW-1:0] i_taps,
    input  logic [gppt_pkg::DW-1:0] i_mask,
    output gppt_pkg::t_lfsr_sts     o_sts
);
    import gppt_pkg::*;

    logic          r_run;
    logic          r_done;
    logic [DW-1:0] r_state;
    logic [DW-1:0] r_steps;
    logic [DW-1:0] r_period;
    logic [DW-1:0] r_taps;
    logic [DW-1:0] r_mask;
    logic          fb;
    logic [DW-1:0] state_nx;
    logic [DW-1:0] steps_nx;

    // one LFSR step
    always_comb begin
        fb       = ^(r_state & r_taps);
        state_nx = {r_state[DW-2:0], fb} & r_mask;
        steps_nx = r_steps + 16'd1;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run) begin
                if ((state_nx == 16'd1) || (steps_nx == r_mask)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_state <= 16'd1;
            r_steps <= '0;
            r_taps  <= i_taps;
            r_mask  <= i_mask;
        end else if (r_run) begin
            r_state <= state_nx;
            r_steps <= steps_nx;
            // return to start wins over hitting the cap on the same step
            r_period <= (state_nx == 16'd1) ? steps_nx : '0;
        end
    end

    assign o_sts.done   = r_done;
    assign o_sts.period = r_period;

endmodule

FILE: rtl/gppt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gppt_checker: port-level checks for the primitive polynomial test
// Watches the command handshake and the consistency of each result word.
// ----------------------------------------------------------------------------
module gppt_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    o_valid,
    input logic                    o_is_primitive,
    input logic                    o_found_divisor,
    input logic [gppt_pkg::DW-1:0] o_lfsr_period
);
    import gppt_pkg::*;

    // a taken word keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && start && !busy |=> busy)
        else $error("busy not raised after a word was taken");

    // the result strobe lasts one cycle and only while busy
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy ##1 !o_valid)
        else $error("result strobe longer than one cycle or outside busy");

    // a divisor forces a zero period and a non-primitive verdict
    a_reducible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found_divisor |-> (o_lfsr_period == '0) && !o_is_primitive)
        else $error("reducible word with nonzero period or primitive flag");

    // a primitive verdict needs a real period
    a_primitive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_primitive |-> (o_lfsr_period != '0))
        else $error("primitive word with zero period");

endmodule

bind gf2_primitive_polynomial_test gppt_checker u_gppt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_is_primitive  (o_is_primitive),
    .o_found_divisor (o_found_divisor),
    .o_lfsr_period   (o_lfsr_period)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gf2_primitive_polynomial_test
// Feeds polynomial words under a range of degree settings, some chosen by
// hand and most drawn at random. Each accepted word is classified by a local
// trial-division and LFSR-period calculation, and every result word from the
// block is checked field by field against the oldest pending verdict.
// ----------------------------------------------------------------------------
module testbench;
    import gppt_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;   // cycles with no word moving

    typedef struct packed {
        logic          is_primitive;
        logic          found_divisor;
        logic [DW-1:0] lfsr_period;
    } t_verdict;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [DEG_W-1:0] i_cfg_wdata = '0;
    logic             start = 1'b0;
    logic [DW-1:0]    i_low_coeffs = '0;
    logic             busy;
    logic             o_valid;
    logic             o_is_primitive;
    logic             o_found_divisor;
    logic [DW-1:0]    o_lfsr_period;

    logic [DW-1:0]    pending_words[$];
    t_verdict         expected_verdicts[$];
    logic [DEG_W-1:0] cur_degree = DEG_RESET;
    logic             word_taken = 1'b0;
    bit               no_gaps = 1'b0;
    int               hold_off = 0;
    int               mismatch_count = 0;

    gf2_primitive_polynomial_test dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .i_low_coeffs    (i_low_coeffs),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_is_primitive  (o_is_primitive),
        .o_found_divisor (o_found_divisor),
        .o_lfsr_period   (o_lfsr_period)
    );

    // 100 MHz clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // register value to working degree: below 2 acts as 2, above 16 as 16
    function automatic int clamp_degree(logic [DEG_W-1:0] value);
        if (value < 2) return 2;
        if (value > MAX_DEGREE) return MAX_DEGREE;
        return int'(value);
    endfunction

    // GF(2) long division of monic p (degree n) by monic d (degree dd)
    function automatic bit divides_exactly(longint unsigned p, int n,
                                           longint unsigned d, int dd);
        longint unsigned rem;
        rem = p;
        for (int k = n; k >= dd; k--) begin
            if (rem[k])
                rem ^= d << (k - dd);
        end
        return rem == 0;
    endfunction

    // Fibonacci LFSR from state 1; 0 when it never comes back within 2^n-1
    function automatic logic [DW-1:0] lfsr_period_of(longint unsigned lowc, int n);
        longint unsigned mask;
        longint unsigned taps;
        longint unsigned s;
        mask = (64'd1 << n) - 1;
        taps = 0;
        s = 1;
        for (int j = 0; j < n; j++) begin
            if (lowc[j])
                taps[n - 1 - j] = 1'b1;
        end
        for (longint unsigned steps = 1; steps <= mask; steps++) begin
            s = ((s << 1) | longint'(^(s & taps))) & mask;
            if (s == 1)
                return steps[DW-1:0];
        end
        return '0;
    endfunction

    // full classification of one polynomial word at a given degree setting
    function automatic t_verdict judge_poly(logic [DW-1:0] coeffs,
                                            logic [DEG_W-1:0] deg_cfg);
        t_verdict v;
        int n;
        longint unsigned order;
        longint unsigned sub;
        longint unsigned poly;
        bit reducible;
        n = clamp_degree(deg_cfg);
        order = (64'd1 << n) - 1;
        poly = (64'(coeffs) & order) | (64'd1 << n);
        reducible = 1'b0;
        // only divisor degrees i with 2^i-1 | 2^n-1 are tried
        for (int i = 1; i <= n / 2 && !reducible; i++) begin
            sub = (64'd1 << i) - 1;
            if (order % sub == 0) begin
                for (longint unsigned lo = 1; lo <= sub && !reducible; lo++)
                    reducible = divides_exactly(poly, n, lo | (64'd1 << i), i);
            end
        end
        v.found_divisor = reducible;
        v.lfsr_period   = reducible ? '0 : lfsr_period_of(poly & order, n);
        v.is_primitive  = !reducible && (64'(v.lfsr_period) == order);
        return v;
    endfunction

    // random word; mostly c0 set with an even count of low terms (odd total)
    function automatic logic [DW-1:0] random_coeffs(logic [DEG_W-1:0] deg_cfg);
        logic [DW-1:0] w;
        logic [DW-1:0] mask;
        w = DW'($urandom);
        mask = DW'((32'd1 << clamp_degree(deg_cfg)) - 1);
        if ($urandom_range(0, 9) < 7) begin
            w[0] = 1'b1;
            if (^(w & mask))
                w[1] = ~w[1];
        end
        return w;
    endfunction

    // driver: word source, new words presented at the falling edge
    always @(negedge i_clk) begin : drive
        int gap;
        if (!i_rst_n) begin
            start <= 1'b0;
            hold_off <= 0;
        end else if (!start || word_taken) begin
            if (start)
                gap = no_gaps ? 0 : $urandom_range(0, 5);
            else
                gap = hold_off;
            if (gap == 0 && pending_words.size() != 0) begin
                start <= 1'b1;
                i_low_coeffs <= pending_words.pop_front();
                hold_off <= 0;
            end else begin
                start <= 1'b0;
                hold_off <= (gap == 0) ? 0 : gap - 1;
            end
        end
    end

    // monitor: tracks the degree register, predicts and checks result words
    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (!i_rst_n) begin
            cur_degree <= DEG_RESET;
            word_taken <= 1'b0;
        end else begin
            if (o_valid) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result word with nothing pending");
                    mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_is_primitive !== want.is_primitive) begin
                        $error("is_primitive: expected %0d, got %0d",
                               want.is_primitive, o_is_primitive);
                        mismatch_count++;
                    end
                    if (o_found_divisor !== want.found_divisor) begin
                        $error("found_divisor: expected %0d, got %0d",
                               want.found_divisor, o_found_divisor);
                        mismatch_count++;
                    end
                    if (o_lfsr_period !== want.lfsr_period) begin
                        $error("lfsr_period: expected %0d, got %0d",
                               want.lfsr_period, o_lfsr_period);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
                expected_verdicts = {expected_verdicts,
                                     judge_poly(i_low_coeffs, cur_degree)};
            word_taken <= start && !busy;
            if (i_cfg_we)
                cur_degree <= i_cfg_wdata;
        end
    end

    // watchdog: gives up after a long stretch with no word in or out
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    // append one word to the source queue
    task automatic add_word(input logic [DW-1:0] w);
        pending_words = {pending_words, w};
    endtask

    // wait for the block to drain completely; polled at the rising edge,
    // where the driver never touches the queue or start
    task automatic settle();
        do
            @(posedge i_clk);
        while (pending_words.size() != 0 || start || busy ||
               expected_verdicts.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // degree register write, only while idle
    task automatic set_degree(input logic [DEG_W-1:0] value);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one phase of random words at a given degree setting
    task automatic random_phase(input logic [DEG_W-1:0] value, input int count);
        set_degree(value);
        @(posedge i_clk);
        no_gaps = ($urandom_range(0, 2) == 0);
        for (int k = 0; k < count; k++)
            add_word(random_coeffs(value));
    endtask

    // stimulus
    initial begin : stimulus
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset degree 8: zero, all ones, primitive, irreducible but not
        // primitive, high bits set, no constant term, x^8+1
        @(posedge i_clk);
        add_word(16'h0000);
        add_word(16'hFFFF);
        add_word(16'h001D);
        add_word(16'h001B);
        add_word(16'hFF1D);
        add_word(16'h001C);
        add_word(16'h0001);

        // degree below range acts as 2
        set_degree(5'd0);
        @(posedge i_clk);
        add_word(16'h0003);
        add_word(16'h0000);
        add_word(16'h0001);
        add_word(16'h0002);
        set_degree(5'd1);
        @(posedge i_clk);
        add_word(16'hFFFF);

        // top of range: above 16 acts as 16
        set_degree(5'd31);
        @(posedge i_clk);
        add_word(16'h002D);
        add_word(16'hFFFF);
        set_degree(5'd17);
        @(posedge i_clk);
        add_word(16'h0000);

        // random words, mostly at small degrees to keep the run short
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0)
                random_phase(5'd2, 10);
            else if (ph == 1)
                random_phase(5'd12, 10);
            else
                random_phase(DEG_W'($urandom_range(0, 12)), 10);
        end

        // a few words at the slow, wide degrees
        random_phase(5'd13, 1);
        random_phase(5'd14, 1);
        random_phase(5'd15, 2);
        random_phase(5'd16, 2);

        settle();
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
